// ===== hdl/dspc_pkg.sv =====
// dspc_pkg: shared constants, nominal tables and helper types for the DAC setpoint calibrator.
// No dependencies.
package dspc_pkg;

  localparam int CODE_MAX = 4095;
  localparam int CUR_MIN  = 1500;
  localparam int CUR_FS   = 22000;
  localparam int VOLT_FS  = 11000;
  localparam int KW       = 24;

  localparam logic [1:0] ST_CODE   = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_UNIT   = 2'd2;
  localparam logic [1:0] ST_STORED = 2'd3;

  localparam logic OP_STORE   = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  localparam logic [1:0] UNIT_CUR  = 2'd0;
  localparam logic [1:0] UNIT_VOLT = 2'd1;

  localparam logic [1:0] MODE_CUR = 2'd0;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_CH1_MODE = 2'd0;
  localparam logic [1:0] REG_CH2_MODE = 2'd1;
  localparam logic [1:0] REG_CH1_CAL  = 2'd2;
  localparam logic [1:0] REG_CH2_CAL  = 2'd3;

  function automatic logic [15:0] nom_ua(input logic [4:0] i);
    logic [15:0] r;
    case (i)
      5'd0: r = 16'd4000;   5'd1: r = 16'd4500;   5'd2: r = 16'd5000;
      5'd3: r = 16'd5500;   5'd4: r = 16'd6000;   5'd5: r = 16'd6500;
      5'd6: r = 16'd7000;   5'd7: r = 16'd7500;   5'd8: r = 16'd8000;
      5'd9: r = 16'd8500;   5'd10: r = 16'd9000;  5'd11: r = 16'd9500;
      5'd12: r = 16'd10000; 5'd13: r = 16'd10500; 5'd14: r = 16'd11000;
      5'd15: r = 16'd12000; 5'd16: r = 16'd12500; 5'd17: r = 16'd13000;
      5'd18: r = 16'd13500; 5'd19: r = 16'd14000; 5'd20: r = 16'd14500;
      5'd21: r = 16'd15000; 5'd22: r = 16'd15500; 5'd23: r = 16'd16000;
      5'd24: r = 16'd16500; 5'd25: r = 16'd17000; 5'd26: r = 16'd17500;
      5'd27: r = 16'd18000; 5'd28: r = 16'd18500; 5'd29: r = 16'd19000;
      5'd30: r = 16'd19500; 5'd31: r = 16'd20000;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] nom_mv(input logic [4:0] i);
    logic [15:0] r;
    case (i)
      5'd0: r = 16'd200;    5'd1: r = 16'd500;    5'd2: r = 16'd750;
      5'd3: r = 16'd1000;   5'd4: r = 16'd1250;   5'd5: r = 16'd1500;
      5'd6: r = 16'd1750;   5'd7: r = 16'd2000;   5'd8: r = 16'd2250;
      5'd9: r = 16'd2500;   5'd10: r = 16'd2750;  5'd11: r = 16'd3000;
      5'd12: r = 16'd3250;  5'd13: r = 16'd3500;  5'd14: r = 16'd4000;
      5'd15: r = 16'd4500;  5'd16: r = 16'd5000;  5'd17: r = 16'd5500;
      5'd18: r = 16'd6000;  5'd19: r = 16'd6500;  5'd20: r = 16'd7000;
      5'd21: r = 16'd7500;  5'd22: r = 16'd7750;  5'd23: r = 16'd8000;
      5'd24: r = 16'd8250;  5'd25: r = 16'd8500;  5'd26: r = 16'd8750;
      5'd27: r = 16'd9000;  5'd28: r = 16'd9250;  5'd29: r = 16'd9500;
      5'd30: r = 16'd9750;  5'd31: r = 16'd10000;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] nom(input logic cur, input logic [4:0] i);
    return cur ? nom_ua(i) : nom_mv(i);
  endfunction

  // Sequencer states.
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SRCH  = 8'b0000_0010,
    S_RD    = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_CHK   = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  // Control to the serial divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

endpackage

// ===== hdl/dspc_div.sv =====
// dspc_div: restoring serial divider, one quotient bit per cycle.
// Depends on dspc_pkg.
module dspc_div #(
  parameter int NW = 48,
  parameter int DW = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dspc_pkg::div_ctl_t ctl,
  input  logic [NW-1:0]     num,
  input  logic [DW-1:0]     den,
  output logic [NW-1:0]     quo,
  output logic              done
);
  import dspc_pkg::*;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] d_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW:0]   trial;

  always_comb begin
    trial    = {rem_r[DW-1:0], q_r[NW-1]};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (ctl.start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (ctl.start) d_r <= den;
  end

  assign quo  = q_r;
  assign done = !busy_r;
endmodule

// ===== hdl/dspc_mul.sv =====
// dspc_mul: serial shift-add multiplier, unsigned A times signed B, one bit of A per cycle.
// Depends on dspc_pkg.
module dspc_mul #(
  parameter int AW = 16,
  parameter int BW = 27
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [AW-1:0]            a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  prod,
  output logic                     done
);
  import dspc_pkg::*;
  localparam int CW = $clog2(AW + 1);

  logic [AW-1:0]              a_r;
  logic signed [AW+BW-1:0]    b_r, acc_r;
  logic [CW-1:0]              cnt_r;
  logic                       busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(AW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_r <= 1'b0;
    end
    if (start) begin
      a_r   <= a;
      b_r   <= (AW+BW)'(b);
      acc_r <= '0;
    end else if (busy_r) begin
      if (a_r[0]) acc_r <= acc_r + b_r;
      a_r <= a_r >> 1;
      b_r <= b_r <<< 1;
    end
  end

  assign prod = acc_r;
  assign done = !busy_r;
endmodule

// ===== hdl/dac_setpoint_calibration_top.sv =====
// DAC setpoint calibrator, two channels, digit-serial datapath.
// Use: drive in_* with in_valid; a transaction is taken when in_valid is high and
// in_stall low. Each transaction gives exactly one result on out_* (out_valid),
// held until out_stall is low. Store transactions (opcode 0) compute
// k = (m - n)/m in Q4.20 with a serial restoring divider and write it
// to the factor memory. Convert transactions (opcode 1) search the nominal table
// one point per cycle, read up to two factors from memory, form
// v*(2 - ksum) with a serial multiplier, range-check, then divide for the
// code with the serial divider. One transaction is processed at a time; the
// next can be accepted as soon as out_valid rises, unless out_stall is high.
// in_stall is high while a transaction is in flight or a stalled result is held; the result
// register is released at the edge it is taken, and the next input is accepted then.
// Reset (rst_n low, synchronous) returns modes to 2, calibrated flags to 0 and
// clears the factor valid bits (one per entry), so all factors read as zero.
// When the receiver stalls, the result and its fields hold steady.
// Configuration: APB registers at 0x0,0x4,0x8,0xC; write only while idle.
module dac_setpoint_calibration_top #(
  parameter int CAL_POINTS = 32,
  parameter int CHANNELS   = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic        in_channel,
  input  logic [1:0]  in_unit,
  input  logic [4:0]  in_point_index,
  input  logic signed [15:0] in_measured_point,
  input  logic [15:0] in_setpoint,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_dac_write,
  output logic        out_dac_select,
  output logic [11:0] out_dac_code,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dspc_pkg::*;

  localparam int NPTS  = (CAL_POINTS < 32) ? CAL_POINTS : 32;
  localparam int DEPTH = CHANNELS * CAL_POINTS;
  localparam int AW    = $clog2(DEPTH);

  // ---------------- configuration ----------------
  logic [1:0] mode1_r, mode2_r;
  logic       cal1_r, cal2_r;
  logic       cfg_wr;
  logic [1:0] cfg_idx;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode1_r <= 2'd2;
      mode2_r <= 2'd2;
      cal1_r  <= 1'b0;
      cal2_r  <= 1'b0;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      case (cfg_idx)
        REG_CH1_MODE: mode1_r <= pwdata[1:0];
        REG_CH2_MODE: mode2_r <= pwdata[1:0];
        REG_CH1_CAL:  cal1_r  <= pwdata[0];
        REG_CH2_CAL:  cal2_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_CH1_MODE: prdata = {30'd0, mode1_r};
      REG_CH2_MODE: prdata = {30'd0, mode2_r};
      REG_CH1_CAL:  prdata = {31'd0, cal1_r};
      REG_CH2_CAL:  prdata = {31'd0, cal2_r};
      default:      prdata = '0;
    endcase
  end

  // ---------------- factor memory ----------------
  logic [KW-1:0]    kmem [DEPTH];
  logic [DEPTH-1:0] kval_r;
  logic             kwe;
  logic [AW-1:0]    kwa, kra;
  logic [KW-1:0]    kwd, krd_r;
  logic             krv_r;

  always_ff @(posedge clk) begin
    if (kwe) kmem[kwa] <= kwd;
    krd_r <= kmem[kra];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kval_r <= '0;
      krv_r  <= 1'b0;
    end else begin
      if (kwe) kval_r[kwa] <= 1'b1;
      krv_r <= kval_r[kra];
    end
  end
  logic signed [KW-1:0] kq;
  assign kq = krv_r ? $signed(krd_r) : '0;

  // ---------------- transaction registers ----------------
  state_t st_r;
  logic        op_r, ch_r;
  logic [1:0]  unit_r;
  logic [4:0]  pt_r;
  logic signed [15:0] m_r;
  logic [15:0] v_r;
  logic        ok_ch;
  assign ok_ch = (32'(ch_r) < CHANNELS);

  logic        cur_tbl;   // table choice for this transaction
  logic        calib;
  always_comb begin
    if (op_r == OP_STORE) cur_tbl = ((ch_r ? mode2_r : mode1_r) == MODE_CUR);
    else                  cur_tbl = (unit_r == UNIT_CUR);
    calib = ch_r ? cal2_r : cal1_r;
  end

  logic [4:0]  idx_r;           // search index
  logic [4:0]  ka_r, kb_r;      // chosen points
  logic        rd2_r;           // second read pending
  logic signed [KW:0] ksum_r;   // Q4.21
  logic [1:0]  rdc_r;

  // out registers
  logic        ov_r, ow_r, osel_r;
  logic [11:0] ocode_r;
  logic [1:0]  ostat_r;

  // units
  div_ctl_t dctl;
  logic [47:0] dnum, dquo;
  logic [39:0] dden;
  logic        ddone;
  logic        mstart, mdone;
  logic signed [26:0] mb;
  logic signed [42:0] mprod;

  dspc_div #(.NW(48), .DW(40)) u_div (
    .clk(clk), .rst_n(rst_n), .ctl(dctl), .num(dnum), .den(dden),
    .quo(dquo), .done(ddone)
  );
  dspc_mul #(.AW(16), .BW(27)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart), .a(v_r), .b(mb),
    .prod(mprod), .done(mdone)
  );
  assign mb = 27'sd2097152 - 27'(ksum_r);

  // store: magnitudes and signs
  logic signed [16:0] diff;
  logic [16:0] adiff, am;
  logic        kneg;
  assign diff  = 17'(m_r) - 17'(nom(cur_tbl, pt_r));
  assign adiff = diff[16] ? 17'(-diff) : diff;
  assign am    = m_r[15] ? 17'(-17'(m_r)) : 17'(m_r);
  assign kneg  = diff[16] != m_r[15];

  // convert: range check and code numerator
  logic signed [42:0] p_r;
  logic signed [63:0] nn;
  logic [39:0] den_fs;
  logic        bad;
  always_comb begin
    den_fs = (unit_r == UNIT_CUR) ? 40'(CUR_FS) << 21 : 40'(VOLT_FS) << 21;
    if (unit_r == UNIT_CUR)
      bad = (p_r < (43'sd1500 <<< 21) && p_r != 0) || p_r > (43'sd22000 <<< 21);
    else
      bad = p_r > (43'sd11000 <<< 21);
  end
  // 8191*FS*2^20 - 4095*p, formed combinationally from shifts (p*4096 - p)
  assign nn = ((unit_r == UNIT_CUR) ? (64'sd8191 * 64'sd22000) <<< 20
                                    : (64'sd8191 * 64'sd11000) <<< 20)
              - ((64'(p_r) <<< 12) - 64'(p_r));
  logic signed [63:0] nn_r;

  // search step: one table point per cycle
  logic [4:0]  lastp;
  logic [15:0] ta, tb;
  logic [16:0] midv;
  assign lastp = 5'(NPTS - 1);
  assign ta    = nom(cur_tbl, idx_r - 5'd1);
  assign tb    = nom(cur_tbl, idx_r);
  assign midv  = (17'(ta) + 17'(tb)) >> 1;

  logic acc_in, acc_out;
  assign acc_in  = in_valid && !in_stall;
  assign acc_out = ov_r && !out_stall;
  assign in_stall = (st_r != S_IDLE) || (ov_r && out_stall);
  assign out_valid = ov_r;
  assign out_dac_write  = ow_r;
  assign out_dac_select = osel_r;
  assign out_dac_code   = ocode_r;
  assign out_status     = ostat_r;

  always_comb begin
    kra   = AW'(ch_r) * AW'(CAL_POINTS) + AW'(rd2_r ? kb_r : ka_r);
    dnum  = '0;
    dden  = '0;
    if (st_r == S_DIV && op_r == OP_STORE) begin
      dnum = (48'(adiff) << 21) + 48'(am);
      dden = 40'(am) << 1;
    end else begin
      dnum = 48'(nn_r[47:0]);
      dden = den_fs;
    end
    kwa = AW'(ch_r) * AW'(CAL_POINTS) + AW'(pt_r);
  end

  logic started_r;
  logic [47:0] q;
  logic [23:0] kres;
  always_comb begin
    q = dquo;
    if (m_r == 0) kres = 24'h800000;
    else if (diff == 0) kres = '0;
    else if (kneg) kres = (q > 48'h800000) ? 24'h800000 : 24'(-q);
    else kres = (q > 48'h7FFFFF) ? 24'h7FFFFF : q[23:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      started_r <= 1'b0;
    end else begin
      if (acc_out && st_r != S_OUT) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: if (acc_in) begin
          op_r <= in_opcode; ch_r <= in_channel; unit_r <= in_unit;
          pt_r <= in_point_index; m_r <= in_measured_point; v_r <= in_setpoint;
          st_r <= (in_opcode == OP_STORE) ? S_DIV : S_CHK;
          started_r <= 1'b0;
          ksum_r <= '0;
          idx_r <= 5'd1;
          rd2_r <= 1'b0;
          rdc_r <= 2'd0;
        end
        S_CHK: begin
          // pre-checks before work
          if (!started_r) begin
            if (unit_r > UNIT_VOLT) begin
              ow_r <= 1'b0; ostat_r <= ST_UNIT; st_r <= S_OUT;
            end else if (!ok_ch) begin
              ow_r <= 1'b0; ostat_r <= ST_RANGE; st_r <= S_OUT;
            end else if (!calib) begin
              st_r <= S_MUL;
            end else if (v_r <= nom(cur_tbl, 5'd0)) begin
              ka_r <= 5'd0; kb_r <= 5'd0; st_r <= S_RD;
            end else if (v_r >= nom(cur_tbl, lastp)) begin
              ka_r <= lastp; kb_r <= lastp; st_r <= S_RD;
            end else st_r <= S_SRCH;
            started_r <= 1'b1;
          end else begin
            if (bad) begin
              ow_r <= 1'b0; ostat_r <= ST_RANGE; st_r <= S_OUT;
            end else begin
              nn_r <= nn;
              st_r <= S_DIV;
              started_r <= 1'b0;
            end
          end
        end
        S_SRCH: begin
          if (17'(v_r) > 17'(ta) && 17'(v_r) <= midv) begin
            ka_r <= idx_r - 5'd1; kb_r <= idx_r; st_r <= S_RD;
          end else if (17'(v_r) > midv && v_r <= tb) begin
            ka_r <= idx_r; kb_r <= idx_r; st_r <= S_RD;
          end else if (idx_r == lastp) begin
            st_r <= S_MUL;
          end else idx_r <= idx_r + 5'd1;
        end
        S_RD: begin
          // address a, then b; each read data is registered and lands in the cycle after its address
          if (rdc_r == 2'd0) rd2_r <= 1'b1;
          if (rdc_r == 2'd1) ksum_r <= 25'(kq);
          if (rdc_r == 2'd2) begin
            ksum_r <= ksum_r + 25'(kq);
            st_r <= S_MUL;
            rdc_r <= 2'd0;
          end else rdc_r <= rdc_r + 2'd1;
        end
        S_MUL: begin
          if (rdc_r == 2'd0) rdc_r <= 2'd1;
          else if (rdc_r == 2'd1) rdc_r <= 2'd2;
          else if (mdone) begin
            p_r <= mprod; st_r <= S_CHK; rdc_r <= 2'd0;
          end
        end
        S_DIV: begin
          if (!started_r) started_r <= 1'b1;
          else if (rdc_r == 2'd0) rdc_r <= 2'd1;
          else if (ddone) st_r <= S_FIN;
        end
        S_FIN: begin
          if (op_r == OP_STORE) begin
            ow_r <= 1'b0;
            ocode_r <= '0;
            ostat_r <= ST_STORED;
          end else begin
            ow_r <= 1'b1;
            ostat_r <= ST_CODE;
            if (nn_r >= $signed(64'(den_fs) << 12)) ocode_r <= 12'(CODE_MAX);
            else if (nn_r < 0) ocode_r <= '0;
            else ocode_r <= dquo[11:0];
          end
          st_r <= S_OUT;
        end
        S_OUT: if (!ov_r || acc_out) begin
          ov_r <= 1'b1;
          osel_r <= ch_r;
          if (ostat_r != ST_CODE) ocode_r <= '0;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // start pulses for the serial units, factor write on store completion
  always_comb begin
    kwe = 1'b0;
    kwd = '0;
    mstart = (st_r == S_MUL) && (rdc_r == 2'd0);
    dctl.start = (st_r == S_DIV) && (rdc_r == 2'd0) && started_r;
    if (st_r == S_FIN && op_r == OP_STORE && ok_ch && 32'(pt_r) < NPTS) begin
      kwe = 1'b1;
      kwd = kres;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    acc_in |=> in_stall) else $error("second transaction accepted while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_dac_write) |-> out_dac_code == 12'd0)
    else $error("code without write");
endmodule

// ===== tb/sv/dac_setpoint_calibration_top_test.sv =====
// Self-checking bench for the DAC setpoint calibrator: drives store and convert
// transactions, predicts each result and compares it with the output channel.
// Depends on dspc_pkg and dac_setpoint_calibration_top.
module dac_setpoint_calibration_top_test;
  import dspc_pkg::*;

  typedef struct packed {
    logic        opcode;
    logic        channel;
    logic [1:0]  unit;
    logic [4:0]  point;
    logic [15:0] measured;
    logic [15:0] setpoint;
  } cal_item_t;

  typedef struct packed {
    logic        dac_write;
    logic        dac_select;
    logic [11:0] dac_code;
    logic [1:0]  status;
  } dac_result_t;

  localparam int NPTS = 32;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = 1'b0;
  logic in_channel = 1'b0;
  logic [1:0] in_unit = '0;
  logic [4:0] in_point_index = '0;
  logic signed [15:0] in_measured_point = '0;
  logic [15:0] in_setpoint = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_dac_write;
  logic out_dac_select;
  logic [11:0] out_dac_code;
  logic [1:0] out_status;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  dac_setpoint_calibration_top i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_channel, .in_unit,
    .in_point_index, .in_measured_point, .in_setpoint, .out_valid, .out_stall,
    .out_dac_write, .out_dac_select, .out_dac_code, .out_status,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state: modes, calibrated flags and the factor table.
  logic [1:0]  mode_q [2];
  logic        cal_q [2];
  logic [23:0] factor_q [2][NPTS];

  cal_item_t   pending_items [$];
  dac_result_t expected_results [$];

  int  errors = 0;
  bit  stim_done = 1'b0;
  bit  quiet = 1'b0;        // last part of run: no idling
  int  hold_cycles = 0;     // receiver long hold-off request
  longint cycle_count = 0;

  // k = round((m-n)*2^20/m) half away from zero, saturated to Q4.20.
  function automatic logic [23:0] calc_factor(int m, int n);
    longint diff, num, den, q;
    bit neg;
    diff = m - n;
    if (m == 0) return 24'h800000;
    if (diff == 0) return 24'h0;
    num = (diff < 0 ? -diff : diff) <<< 20;
    den = (m < 0 ? -m : m);
    q = (2 * num + den) / (2 * den);
    neg = (diff < 0) != (m < 0);
    if (neg) begin
      if (q > 64'h800000) q = 64'h800000;
      return 24'(-q);
    end
    if (q > 64'h7FFFFF) q = 64'h7FFFFF;
    return 24'(q);
  endfunction

  function automatic longint factor_val(logic ch, int p);
    return longint'($signed(factor_q[ch][p]));
  endfunction

  // Factor sum in Q4.21 selected by point or midpoint neighborhood.
  function automatic longint pick_factor_sum(logic ch, bit cur, int v);
    int lo, hi, mid;
    if (v <= nom(cur, 5'd0)) return 2 * factor_val(ch, 0);
    if (v >= nom(cur, 5'(NPTS - 1))) return 2 * factor_val(ch, NPTS - 1);
    for (int i = 1; i < NPTS; i++) begin
      lo = nom(cur, 5'(i - 1));
      hi = nom(cur, 5'(i));
      mid = (lo + hi) / 2;
      if (v > lo && v <= mid) return factor_val(ch, i - 1) + factor_val(ch, i);
      if (v > mid && v <= hi) return 2 * factor_val(ch, i);
    end
    return 0;
  endfunction

  function automatic dac_result_t predict_dac(cal_item_t it);
    dac_result_t r;
    longint ksum, p, fs, den, nn;
    bit bad, cur;
    r = '0;
    r.dac_select = it.channel;
    if (it.opcode == OP_STORE) begin
      r.status = ST_STORED;
      factor_q[it.channel][it.point] = calc_factor(int'($signed(it.measured)),
        int'(nom(mode_q[it.channel] == MODE_CUR, it.point)));
      return r;
    end
    if (it.unit != UNIT_CUR && it.unit != UNIT_VOLT) begin
      r.status = ST_UNIT;
      return r;
    end
    cur = (it.unit == UNIT_CUR);
    ksum = cal_q[it.channel] ? pick_factor_sum(it.channel, cur, int'(it.setpoint)) : 0;
    p = longint'(it.setpoint) * ((64'sd1 <<< 21) - ksum);
    fs = cur ? CUR_FS : VOLT_FS;
    if (cur)
      bad = (p < (longint'(CUR_MIN) <<< 21) && p != 0) || p > (longint'(CUR_FS) <<< 21);
    else
      bad = p > (longint'(VOLT_FS) <<< 21);
    if (bad) begin
      r.status = ST_RANGE;
      return r;
    end
    den = fs <<< 21;
    nn = 8191 * fs * (64'sd1 <<< 20) - 4095 * p;
    if (nn >= 4096 * den) r.dac_code = 12'(CODE_MAX);
    else if (nn < 0) r.dac_code = '0;
    else r.dac_code = 12'(nn / den);
    r.dac_write = 1'b1;
    r.status = ST_CODE;
    return r;
  endfunction

  // Capture the stall seen at the rising edge so the driver knows acceptance.
  cal_item_t cur_item;
  logic in_stall_at_edge = 1'b1;
  always @(posedge clk) in_stall_at_edge <= in_stall;

  // Driver: one transaction offered at a time, random idle bursts between.
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_at_edge) begin
        // previous transaction was accepted at the last rising edge
        void'(pending_items.pop_front());
        expected_results.push_back(predict_dac(cur_item));
        if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 13);
      end
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap = send_gap - 1;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items[0];
        in_valid <= 1'b1;
        in_opcode <= cur_item.opcode;
        in_channel <= cur_item.channel;
        in_unit <= cur_item.unit;
        in_point_index <= cur_item.point;
        in_measured_point <= cur_item.measured;
        in_setpoint <= cur_item.setpoint;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random bursts, or a long hold-off when requested.
  int stall_left = 0;
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  dac_result_t got, want;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_dac_write, out_dac_select, out_dac_code, out_status};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.dac_write !== want.dac_write)
          $display("%0t: dac_write exp %0d got %0d", $realtime, want.dac_write, got.dac_write);
        if (got.dac_select !== want.dac_select)
          $display("%0t: dac_select exp %0d got %0d", $realtime, want.dac_select,
                   got.dac_select);
        if (got.dac_code !== want.dac_code)
          $display("%0t: dac_code exp %0d got %0d", $realtime, want.dac_code, got.dac_code);
        if (got.status !== want.status)
          $display("%0t: status exp %0d got %0d", $realtime, want.status, got.status);
        if (got !== want) errors++;
      end
    end
  end

  // APB write: setup then access; pready is always high.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_CH1_MODE: mode_q[0] = val[1:0];
      REG_CH2_MODE: mode_q[1] = val[1:0];
      REG_CH1_CAL:  cal_q[0] = val[0];
      default:      cal_q[1] = val[0];
    endcase
  endtask

  // Block until every pending and expected transaction is done.
  task automatic drain();
    while (pending_items.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic cal_item_t make_item(logic op, logic ch, logic [1:0] u,
                                          logic [4:0] pt, logic [15:0] m, logic [15:0] v);
    return '{op, ch, u, pt, m, v};
  endfunction

  // Measured value near nominal so k stays in a realistic band.
  function automatic logic [15:0] near_meas(logic ch, logic [4:0] pt);
    int n;
    n = nom(mode_q[ch] == MODE_CUR, pt);
    return 16'(n + $signed($urandom_range(0, 2 * (n / 20 + 2))) - (n / 20 + 2));
  endfunction

  function automatic cal_item_t rand_item();
    cal_item_t it;
    int sel;
    it = cal_item_t'(41'({$urandom, $urandom}));
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      it.opcode = OP_STORE;
      if (sel < 3) it.measured = near_meas(it.channel, it.point);
    end else begin
      it.opcode = OP_CONVERT;
      if (sel < 9) begin
        it.unit = $urandom_range(0, 1) ? UNIT_CUR : UNIT_VOLT;
        it.setpoint = (it.unit == UNIT_CUR) ? 16'($urandom_range(0, 23000))
                                            : 16'($urandom_range(0, 11500));
      end
    end
    return it;
  endfunction

  initial begin
    mode_q[0] = 2'd2; mode_q[1] = 2'd2; cal_q[0] = 1'b0; cal_q[1] = 1'b0;
    for (int c = 0; c < 2; c++)
      for (int p = 0; p < NPTS; p++) factor_q[c][p] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: uncalibrated converts, then stores with the special cases and calibrated converts.
    pending_items.push_back(make_item(OP_CONVERT, 1'b0, UNIT_CUR, 5'd0, 16'd0, 16'd0));
    pending_items.push_back(make_item(OP_CONVERT, 1'b0, UNIT_CUR, 5'd0, 16'd0, 16'd1499));
    pending_items.push_back(make_item(OP_CONVERT, 1'b1, UNIT_CUR, 5'd0, 16'd0, 16'd22000));
    pending_items.push_back(make_item(OP_CONVERT, 1'b1, UNIT_CUR, 5'd0, 16'd0, 16'd22001));
    pending_items.push_back(make_item(OP_CONVERT, 1'b0, UNIT_VOLT, 5'd0, 16'd0, 16'd11000));
    pending_items.push_back(make_item(OP_CONVERT, 1'b0, UNIT_VOLT, 5'd0, 16'd0, 16'hFFFF));
    pending_items.push_back(make_item(OP_CONVERT, 1'b1, 2'd2, 5'd0, 16'd0, 16'd500));
    pending_items.push_back(make_item(OP_CONVERT, 1'b1, 2'd3, 5'd0, 16'd0, 16'd500));
    drain();
    write_reg(REG_CH1_MODE, 32'd0);
    write_reg(REG_CH2_MODE, 32'd1);
    write_reg(REG_CH1_CAL, 32'd1);
    write_reg(REG_CH2_CAL, 32'd1);
    // measured zero and full-scale measured values
    pending_items.push_back(make_item(OP_STORE, 1'b0, UNIT_CUR, 5'd0, 16'd0, 16'd0));
    pending_items.push_back(make_item(OP_STORE, 1'b0, UNIT_CUR, 5'd31, 16'sh7FFF, 16'd0));
    pending_items.push_back(make_item(OP_STORE, 1'b0, UNIT_CUR, 5'd1, 16'sh8000, 16'd0));
    // k overflow
    pending_items.push_back(make_item(OP_STORE, 1'b0, UNIT_CUR, 5'd2, 16'd1, 16'd0));
    // k exactly zero
    pending_items.push_back(make_item(OP_STORE, 1'b0, UNIT_CUR, 5'd3, 16'd5500, 16'd0));
    pending_items.push_back(make_item(OP_STORE, 1'b1, UNIT_CUR, 5'd0, 16'd210, 16'd0));
    pending_items.push_back(make_item(OP_STORE, 1'b1, UNIT_CUR, 5'd1, 16'd480, 16'd0));
    pending_items.push_back(make_item(OP_CONVERT, 1'b0, UNIT_CUR, 5'd0, 16'd0, 16'd4000));
    pending_items.push_back(make_item(OP_CONVERT, 1'b0, UNIT_CUR, 5'd0, 16'd0, 16'd4250));
    pending_items.push_back(make_item(OP_CONVERT, 1'b0, UNIT_CUR, 5'd0, 16'd0, 16'd20000));
    pending_items.push_back(make_item(OP_CONVERT, 1'b1, UNIT_VOLT, 5'd0, 16'd0, 16'd300));
    pending_items.push_back(make_item(OP_CONVERT, 1'b1, UNIT_VOLT, 5'd0, 16'd0, 16'd400));
    pending_items.push_back(make_item(OP_CONVERT, 1'b1, UNIT_VOLT, 5'd0, 16'd0, 16'd0));
    drain();

    // Random phases across register settings.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_CH1_MODE, 32'($urandom_range(0, 2)));
      write_reg(REG_CH2_MODE, ph == 5 ? 32'd3 : 32'($urandom_range(0, 2)));
      write_reg(REG_CH1_CAL, 32'(ph != 0));
      write_reg(REG_CH2_CAL, 32'($urandom_range(0, 1)));
      for (int i = 0; i < 270; i++) pending_items.push_back(rand_item());
      if (ph == 2) begin
        // long receiver hold-off while the sender keeps offering
        @(negedge clk);
        hold_cycles = 600;
      end
      if (ph == 5) quiet = 1'b1;
      drain();
    end
    stim_done = 1'b1;
  end

  // End of run and watchdog.
  initial begin
    wait (stim_done || cycle_count >= CYCLE_LIMIT);
    if (!stim_done) begin
      $display("dac_setpoint_calibration_top: mismatch");
      $finish;
    end else begin
      if (errors == 0)
        $display("dac_setpoint_calibration_top: match");
      else
        $display("dac_setpoint_calibration_top: mismatch");
      $finish;
    end
  end

endmodule
